>>> hw/rtl/lpm_pkg.sv
// Shared types and constants for the longest-prefix-match route lookup.
// Holds the input and result word types and the word that runs down the cell chain.
// No dependencies.
package lpm_pkg;

  // Field widths fixed by the word format.
  localparam int IndexWidth = 4;
  localparam int AddrWidth  = 32;
  localparam int PortWidth  = 4;

  // Command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // One input word.
  typedef struct packed {
    logic                  command;
    logic [IndexWidth-1:0] entry_index;
    logic [AddrWidth-1:0]  entry_prefix;
    logic [AddrWidth-1:0]  entry_mask;
    logic [PortWidth-1:0]  entry_port;
    logic                  entry_valid;
    logic [AddrWidth-1:0]  lookup_address;
  } lpm_in_t;

  // One result word.
  typedef struct packed {
    logic                 hit;
    logic [PortWidth-1:0] out_port;
    logic [AddrWidth-1:0] matched_mask;
  } lpm_out_t;

  // Word carried from cell to cell: the command and, for a lookup,
  // the best match found so far.
  typedef struct packed {
    logic                  is_lookup;
    logic [IndexWidth-1:0] entry_index;
    logic [AddrWidth-1:0]  entry_prefix;
    logic [AddrWidth-1:0]  entry_mask;
    logic [PortWidth-1:0]  entry_port;
    logic                  entry_valid;
    logic [AddrWidth-1:0]  lookup_address;
    logic                  found;
    logic [AddrWidth-1:0]  best_mask;
    logic [PortWidth-1:0]  best_port;
  } lpm_word_t;

endpackage

>>> hw/rtl/longest_prefix_match_lookup.sv
// IPv4 longest-prefix-match route lookup, top level.
// A chain of TABLE_ENTRIES route cells plus an output register. Depends on lpm_pkg, lpm_cell.
//
// Every word, write or lookup, enters cell 0 and moves one cell per cycle down
// a chain of TABLE_ENTRIES cells, each of which holds one route entry. A write
// loads the cell whose number equals entry_index and gives no result; writes to
// a slot beyond the table or with a port at or above PORT_COUNT are dropped. A
// lookup picks up the best match as it passes each cell and leaves the chain
// into the output register after the stage registers of all TABLE_ENTRIES
// cells. A new word is accepted every cycle while the output register is
// empty or being taken, and since words never pass each other a lookup
// always sees exactly the writes accepted before it. When the output stalls
// the whole chain holds. Reset clears all entry valid bits.
module longest_prefix_match_lookup #(
  parameter int TABLE_ENTRIES = 16,
  parameter int PORT_COUNT    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpm_pkg::lpm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpm_pkg::lpm_out_t out_data
);

  logic               advance;
  logic               in_keep;
  lpm_pkg::lpm_word_t head_word;
  logic               chain_vld  [TABLE_ENTRIES+1];
  lpm_pkg::lpm_word_t chain_word [TABLE_ENTRIES+1];
  logic               out_valid_r;
  logic               out_valid_nxt;
  lpm_pkg::lpm_out_t  out_data_r;
  lpm_pkg::lpm_out_t  out_data_nxt;

  // The chain moves whenever the output register is free or being emptied.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // Writes with an out-of-range port never enter the chain.
  assign in_keep = (in_data.command == lpm_pkg::CMD_LOOKUP) ||
                   (32'(in_data.entry_port) < 32'(PORT_COUNT));

  // Build the word that enters the first cell.
  always_comb begin
    head_word.is_lookup      = (in_data.command == lpm_pkg::CMD_LOOKUP);
    head_word.entry_index    = in_data.entry_index;
    head_word.entry_prefix   = in_data.entry_prefix;
    head_word.entry_mask     = in_data.entry_mask;
    head_word.entry_port     = in_data.entry_port;
    head_word.entry_valid    = in_data.entry_valid;
    head_word.lookup_address = in_data.lookup_address;
    head_word.found          = 1'b0;
    head_word.best_mask      = '0;
    head_word.best_port      = '0;
  end

  assign chain_vld[0]  = in_valid && in_keep;
  assign chain_word[0] = head_word;

  // The row of route cells.
  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
    lpm_cell #(
      .CELL_INDEX (gi)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .word_vld_i (chain_vld[gi]),
      .word_i     (chain_word[gi]),
      .word_vld_o (chain_vld[gi+1]),
      .word_o     (chain_word[gi+1])
    );
  end

  // Only lookups leaving the chain become results.
  always_comb begin
    out_valid_nxt             = chain_vld[TABLE_ENTRIES] && chain_word[TABLE_ENTRIES].is_lookup;
    out_data_nxt.hit          = chain_word[TABLE_ENTRIES].found;
    out_data_nxt.out_port     = chain_word[TABLE_ENTRIES].best_port;
    out_data_nxt.matched_mask = chain_word[TABLE_ENTRIES].best_mask;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A miss reports a zero port and a zero mask.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.hit) |->
      (out_data_r.out_port == '0 && out_data_r.matched_mask == '0))
    else $error("miss result carries a nonzero port or mask");

  // While the output stalls, the last cell holds its word.
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(chain_vld[TABLE_ENTRIES]))
    else $error("chain moved while the output was stalled");

  // A new result only comes from a lookup leaving the chain.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      $past(chain_vld[TABLE_ENTRIES] && chain_word[TABLE_ENTRIES].is_lookup))
    else $error("result produced without a lookup leaving the chain");
`endif

endmodule

>>> hw/rtl/lpm_cell.sv
// One route table slot of the lookup chain.
// Holds a single route entry, loads it from passing write words and updates
// passing lookup words with the best match so far. Depends on lpm_pkg.
module lpm_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              word_vld_i,
  input  lpm_pkg::lpm_word_t word_i,
  output logic              word_vld_o,
  output lpm_pkg::lpm_word_t word_o
);

  logic                            ent_valid_r;
  logic [lpm_pkg::AddrWidth-1:0]   ent_prefix_r;
  logic [lpm_pkg::AddrWidth-1:0]   ent_mask_r;
  logic [lpm_pkg::PortWidth-1:0]   ent_port_r;
  logic                            word_vld_r;
  lpm_pkg::lpm_word_t              word_r;
  lpm_pkg::lpm_word_t              word_nxt;
  logic                            write_sel;
  logic                            ent_match;

  // A write word addressed to this slot loads it.
  assign write_sel = advance && word_vld_i && !word_i.is_lookup &&
                     (32'(word_i.entry_index) == 32'(CELL_INDEX));

  // The entry matches when it is valid and the masked address equals its prefix.
  assign ent_match = ent_valid_r &&
                     ((word_i.lookup_address & ent_mask_r) == ent_prefix_r);

  // Update the running best match. Earlier cells win ties, so only a
  // strictly greater mask replaces an earlier hit.
  always_comb begin
    word_nxt = word_i;
    if (word_i.is_lookup && ent_match &&
        (!word_i.found || (ent_mask_r > word_i.best_mask))) begin
      word_nxt.found     = 1'b1;
      word_nxt.best_mask = ent_mask_r;
      word_nxt.best_port = ent_port_r;
    end
  end

  // Entry storage; only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (write_sel) begin
      ent_valid_r <= word_i.entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (write_sel) begin
      ent_prefix_r <= word_i.entry_prefix;
      ent_mask_r   <= word_i.entry_mask;
      ent_port_r   <= word_i.entry_port;
    end
  end

  // Stage register toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= 1'b0;
    end else if (advance) begin
      word_vld_r <= word_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_r <= word_nxt;
    end
  end

  assign word_vld_o = word_vld_r;
  assign word_o     = word_r;

endmodule
